@@ rtl/core/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, operation and status codes for the banker's safety allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    localparam int unsigned PROCESSES_DEFAULT = 5;
    localparam int unsigned RESOURCES         = 3;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned PROC_W = 3;
    localparam int unsigned RES_W  = 2;
    localparam int unsigned AMT_W  = 8;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned CNT_W  = 3;

    typedef logic [AMT_W-1:0] amt_t;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST    = 2'd0,
        OP_RELEASE    = 2'd1,
        OP_LOAD_ROW   = 2'd2,
        OP_LOAD_AVAIL = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_OVER_NEED  = 3'd1,
        ST_OVER_AVAIL = 3'd2,
        ST_UNSAFE     = 3'd3,
        ST_REFUSED    = 3'd4,
        ST_LOADED     = 3'd5
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/bsa_req_if.sv @@
// ----------------------------------------------------------------------------
// bsa_req_if
// Valid/ready channel carrying one operation item into the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_req_if;
    logic                            valid;
    logic                            ready;
    logic [bsa_pkg::OP_W-1:0]        operation;
    logic [bsa_pkg::PROC_W-1:0]      process;
    logic [bsa_pkg::RES_W-1:0]       resource;
    logic [bsa_pkg::AMT_W-1:0]       amount_a;
    logic [bsa_pkg::AMT_W-1:0]       amount_b;
    logic [bsa_pkg::AMT_W-1:0]       amount_c;
    logic [bsa_pkg::AMT_W-1:0]       extra_a;
    logic [bsa_pkg::AMT_W-1:0]       extra_b;
    logic [bsa_pkg::AMT_W-1:0]       extra_c;

    modport source (
        output valid, operation, process, resource,
        output amount_a, amount_b, amount_c, extra_a, extra_b, extra_c,
        input  ready
    );

    modport sink (
        input  valid, operation, process, resource,
        input  amount_a, amount_b, amount_c, extra_a, extra_b, extra_c,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/bsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bsa_rsp_if
// Valid/ready channel carrying one result item out of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bsa_pkg::STAT_W-1:0]      status;
    logic [bsa_pkg::CNT_W-1:0]       finished_count;
    logic [bsa_pkg::PROC_W-1:0]      seq_position;
    logic [bsa_pkg::PROC_W-1:0]      seq_process;
    logic                            last;

    modport source (
        output valid, status, finished_count, seq_position, seq_process, last,
        input  ready
    );

    modport sink (
        input  valid, status, finished_count, seq_position, seq_process, last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/bsa_lane.sv @@
// ----------------------------------------------------------------------------
// bsa_lane
// One process lane: flags a row whose remaining need fits the work vector.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_lane #(
    parameter int unsigned WORK_W = bsa_pkg::AMT_W + 3
) (
    input  wire bsa_pkg::amt_t [bsa_pkg::RESOURCES-1:0] need_row,
    input  wire logic [bsa_pkg::RESOURCES-1:0][WORK_W-1:0] work,
    input  wire logic                                    done,
    output logic                                         fit
);

    logic [bsa_pkg::RESOURCES-1:0] covered;

    always_comb
    begin
        for (int r = 0; r < bsa_pkg::RESOURCES; r++)
        begin
            covered[r] = (WORK_W'(need_row[r]) <= work[r]);
        end
        fit = !done && (&covered);
    end

endmodule

`default_nettype wire

@@ rtl/core/bsa_merge.sv @@
// ----------------------------------------------------------------------------
// bsa_merge
// Merge stage: picks the lowest-numbered lane that fits.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_merge #(
    parameter int unsigned PROCESSES = bsa_pkg::PROCESSES_DEFAULT,
    parameter int unsigned PW        = $clog2(bsa_pkg::PROCESSES_DEFAULT)
) (
    input  wire logic [PROCESSES-1:0] fit,
    output logic                      found,
    output logic [PW-1:0]             idx
);

    always_comb
    begin
        idx   = '0;
        found = |fit;
        for (int i = PROCESSES - 1; i >= 0; i--)
        begin
            if (fit[i])
            begin
                idx = PW'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/banker_safety_allocator_top.sv @@
// ----------------------------------------------------------------------------
// banker_safety_allocator_top
// Banker's algorithm allocator: request, release and table loads with a
// lane-parallel safety scan.
// ----------------------------------------------------------------------------
// One item is in work at a time; the input is ready again as soon as the last
// result has been placed in the output register. Release and load items pass
// from the check state to the emit state. A request is checked in the check
// state, then scanned in steps (the fit state evaluates all process lanes at
// once, the pick state merges and adds the finishing row to the work vector),
// with up to PROCESSES + 1 steps before its first result; a granted request
// then delivers PROCESSES results, one per cycle when the sink keeps ready
// high. The scan loop through the lane/merge stage sets the request latency.
`default_nettype none

module banker_safety_allocator_top #(
    parameter int unsigned PROCESSES = bsa_pkg::PROCESSES_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bsa_req_if.sink   req,
    bsa_rsp_if.source rsp
);

    localparam int unsigned NR     = bsa_pkg::RESOURCES;
    localparam int unsigned AW     = bsa_pkg::AMT_W;
    localparam int unsigned PW     = $clog2(PROCESSES);
    localparam int unsigned CW     = $clog2(PROCESSES + 1);
    localparam int unsigned WORK_W = AW + CW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_FIT,
        S_SCAN_PICK,
        S_EMIT
    } state_t;

    state_t                               state_reg;
    bsa_pkg::op_t                         op_reg;
    logic [bsa_pkg::PROC_W-1:0]           proc_reg;
    logic [bsa_pkg::RES_W-1:0]            res_reg;
    bsa_pkg::amt_t [NR-1:0]               amt_reg;
    bsa_pkg::amt_t [NR-1:0]               ext_reg;

    bsa_pkg::amt_t [NR-1:0]               avail_reg;
    bsa_pkg::amt_t [PROCESSES-1:0][NR-1:0] alloc_reg;
    bsa_pkg::amt_t [PROCESSES-1:0][NR-1:0] need_reg;
    logic [PROCESSES-1:0][bsa_pkg::PROC_W-1:0] safe_reg;

    logic [NR-1:0][WORK_W-1:0]            work_reg;
    logic [PROCESSES-1:0]                 done_reg;
    logic [PROCESSES-1:0]                 fit_reg;
    logic [CW-1:0]                        cnt_reg;
    logic                                 grant_reg;
    bsa_pkg::status_t                     stat_reg;
    logic [bsa_pkg::CNT_W-1:0]            fc_reg;
    logic [PW-1:0]                        emit_k_reg;

    logic                                 out_valid_reg;
    bsa_pkg::status_t                     out_status_reg;
    logic [bsa_pkg::CNT_W-1:0]            out_fc_reg;
    logic [bsa_pkg::PROC_W-1:0]           out_pos_reg;
    logic [bsa_pkg::PROC_W-1:0]           out_proc_reg;
    logic                                 out_last_reg;

    logic [PW-1:0]                        row;
    logic                                 in_range;
    logic                                 res_ok;
    logic [NR-1:0][AW:0]                  alloc_sum;
    logic                                 req_fail;
    bsa_pkg::status_t                     req_stat;
    logic [AW:0]                          rel_avail_sum;
    logic [AW:0]                          rel_need_sum;
    logic                                 rel_ok;
    logic [PROCESSES-1:0]                 fit_vec;
    logic                                 pick_found;
    logic [PW-1:0]                        pick_idx;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.finished_count = out_fc_reg;
    assign rsp.seq_position   = out_pos_reg;
    assign rsp.seq_process    = out_proc_reg;
    assign rsp.last           = out_last_reg;

    assign row      = PW'(proc_reg);
    assign in_range = (32'(proc_reg) < 32'(PROCESSES));
    assign res_ok   = (32'(res_reg) < 32'(NR));

    always_comb
    begin
        req_fail = 1'b0;
        req_stat = bsa_pkg::ST_OVER_NEED;
        for (int r = 0; r < NR; r++)
        begin
            alloc_sum[r] = {1'b0, amt_reg[r]} + {1'b0, alloc_reg[row][r]};
        end
        for (int r = 0; r < NR; r++)
        begin
            if (!req_fail)
            begin
                if (amt_reg[r] > need_reg[row][r])
                begin
                    req_fail = 1'b1;
                    req_stat = bsa_pkg::ST_OVER_NEED;
                end
                else if (amt_reg[r] > avail_reg[r] || alloc_sum[r][AW])
                begin
                    req_fail = 1'b1;
                    req_stat = bsa_pkg::ST_OVER_AVAIL;
                end
            end
        end
    end

    always_comb
    begin
        rel_avail_sum = {1'b0, avail_reg[res_reg]} + {1'b0, amt_reg[0]};
        rel_need_sum  = {1'b0, need_reg[row][res_reg]} + {1'b0, amt_reg[0]};
        rel_ok        = in_range && res_ok
                        && (amt_reg[0] <= alloc_reg[row][res_reg])
                        && !rel_avail_sum[AW] && !rel_need_sum[AW];
    end

    for (genvar p = 0; p < PROCESSES; p++)
    begin : g_lane
        bsa_lane #(
            .WORK_W (WORK_W)
        ) u_lane (
            .need_row (need_reg[p]),
            .work     (work_reg),
            .done     (done_reg[p]),
            .fit      (fit_vec[p])
        );
    end

    bsa_merge #(
        .PROCESSES (PROCESSES),
        .PW        (PW)
    ) u_merge (
        .fit   (fit_reg),
        .found (pick_found),
        .idx   (pick_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= bsa_pkg::OP_REQUEST;
            proc_reg       <= '0;
            res_reg        <= '0;
            amt_reg        <= '0;
            ext_reg        <= '0;
            avail_reg      <= '0;
            alloc_reg      <= '0;
            need_reg       <= '0;
            safe_reg       <= '0;
            work_reg       <= '0;
            done_reg       <= '0;
            fit_reg        <= '0;
            cnt_reg        <= '0;
            grant_reg      <= 1'b0;
            stat_reg       <= bsa_pkg::ST_GRANTED;
            fc_reg         <= '0;
            emit_k_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= bsa_pkg::ST_GRANTED;
            out_fc_reg     <= '0;
            out_pos_reg    <= '0;
            out_proc_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (rsp.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg     <= bsa_pkg::op_t'(req.operation);
                        proc_reg   <= req.process;
                        res_reg    <= req.resource;
                        amt_reg[0] <= req.amount_a;
                        amt_reg[1] <= req.amount_b;
                        amt_reg[2] <= req.amount_c;
                        ext_reg[0] <= req.extra_a;
                        ext_reg[1] <= req.extra_b;
                        ext_reg[2] <= req.extra_c;
                        state_reg  <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    grant_reg  <= 1'b0;
                    fc_reg     <= '0;
                    emit_k_reg <= '0;
                    state_reg  <= S_EMIT;
                    unique case (op_reg)
                        bsa_pkg::OP_REQUEST:
                        begin
                            if (!in_range)
                            begin
                                stat_reg <= bsa_pkg::ST_OVER_NEED;
                            end
                            else if (req_fail)
                            begin
                                stat_reg <= req_stat;
                            end
                            else
                            begin
                                // apply tentatively, then scan
                                for (int r = 0; r < NR; r++)
                                begin
                                    avail_reg[r]      <= avail_reg[r] - amt_reg[r];
                                    alloc_reg[row][r] <= alloc_reg[row][r] + amt_reg[r];
                                    need_reg[row][r]  <= need_reg[row][r] - amt_reg[r];
                                    work_reg[r]       <= WORK_W'(avail_reg[r] - amt_reg[r]);
                                end
                                done_reg  <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_SCAN_FIT;
                            end
                        end

                        bsa_pkg::OP_RELEASE:
                        begin
                            if (rel_ok)
                            begin
                                avail_reg[res_reg]     <= avail_reg[res_reg] + amt_reg[0];
                                alloc_reg[row][res_reg] <= alloc_reg[row][res_reg]
                                                           - amt_reg[0];
                                need_reg[row][res_reg]  <= need_reg[row][res_reg]
                                                           + amt_reg[0];
                                stat_reg <= bsa_pkg::ST_GRANTED;
                            end
                            else
                            begin
                                stat_reg <= bsa_pkg::ST_REFUSED;
                            end
                        end

                        bsa_pkg::OP_LOAD_ROW:
                        begin
                            if (in_range)
                            begin
                                alloc_reg[row] <= amt_reg;
                                need_reg[row]  <= ext_reg;
                            end
                            stat_reg <= bsa_pkg::ST_LOADED;
                        end

                        bsa_pkg::OP_LOAD_AVAIL:
                        begin
                            avail_reg <= amt_reg;
                            stat_reg  <= bsa_pkg::ST_LOADED;
                        end
                    endcase
                end

                S_SCAN_FIT:
                begin
                    fit_reg   <= fit_vec;
                    state_reg <= S_SCAN_PICK;
                end

                S_SCAN_PICK:
                begin
                    if (pick_found)
                    begin
                        for (int r = 0; r < NR; r++)
                        begin
                            work_reg[r] <= work_reg[r] + WORK_W'(alloc_reg[pick_idx][r]);
                        end
                        done_reg[pick_idx]       <= 1'b1;
                        safe_reg[cnt_reg[PW-1:0]] <= bsa_pkg::PROC_W'(pick_idx);
                        cnt_reg                  <= cnt_reg + 1'b1;
                        state_reg                <= S_SCAN_FIT;
                    end
                    else if (cnt_reg == CW'(PROCESSES))
                    begin
                        grant_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        // roll back the tentative allocation
                        for (int r = 0; r < NR; r++)
                        begin
                            avail_reg[r]      <= avail_reg[r] + amt_reg[r];
                            alloc_reg[row][r] <= alloc_reg[row][r] - amt_reg[r];
                            need_reg[row][r]  <= need_reg[row][r] + amt_reg[r];
                        end
                        stat_reg  <= bsa_pkg::ST_UNSAFE;
                        fc_reg    <= bsa_pkg::CNT_W'(cnt_reg);
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (grant_reg)
                        begin
                            out_status_reg <= bsa_pkg::ST_GRANTED;
                            out_fc_reg     <= bsa_pkg::CNT_W'(PROCESSES);
                            out_pos_reg    <= bsa_pkg::PROC_W'(emit_k_reg);
                            out_proc_reg   <= safe_reg[emit_k_reg];
                            if (emit_k_reg == PW'(PROCESSES - 1))
                            begin
                                out_last_reg <= 1'b1;
                                emit_k_reg   <= '0;
                                state_reg    <= S_IDLE;
                            end
                            else
                            begin
                                out_last_reg <= 1'b0;
                                emit_k_reg   <= emit_k_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            out_status_reg <= stat_reg;
                            out_fc_reg     <= fc_reg;
                            out_pos_reg    <= '0;
                            out_proc_reg   <= '0;
                            out_last_reg   <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bsa_checker.sv @@
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the allocator's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [bsa_pkg::STAT_W-1:0]    status,
    input wire logic [bsa_pkg::CNT_W-1:0]     finished_count,
    input wire logic [bsa_pkg::PROC_W-1:0]    seq_position,
    input wire logic [bsa_pkg::PROC_W-1:0]    seq_process,
    input wire logic                          last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(seq_process) && $stable(last))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    a_only_grant_multi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == bsa_pkg::ST_GRANTED)
        else $error("non-final result on a single-result item");

    a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bsa_pkg::ST_GRANTED && status != bsa_pkg::ST_UNSAFE
            |-> finished_count == '0 && seq_position == '0 && seq_process == '0)
        else $error("scan fields set on a result without a scan");

    a_unsafe_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bsa_pkg::ST_UNSAFE |-> last && seq_position == '0)
        else $error("unsafe result not a single final result");

endmodule

bind banker_safety_allocator_top bsa_checker u_bsa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .finished_count (rsp.finished_count),
    .seq_position   (rsp.seq_position),
    .seq_process    (rsp.seq_process),
    .last           (rsp.last)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for banker_safety_allocator_top. A directed opening
// covers every operation and the refusal and overflow corners. Random table
// loads follow, each with requests sized to pass the need and available
// checks, releases and noise items. Each accepted transfer is predicted in
// the bench, and the results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import bsa_pkg::*;

    localparam int NPROC          = int'(PROCESSES_DEFAULT);
    localparam int NRES           = int'(RESOURCES);
    localparam int ITEM_TARGET    = 370;
    localparam int CALM_TAIL      = 50;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int AMT_MAX        = 255;

    typedef struct packed {
        op_t               operation;
        logic [PROC_W-1:0] proc_id;
        logic [RES_W-1:0]  resource;
        amt_t [NRES-1:0]   amount;
        amt_t [NRES-1:0]   extra;
    } op_item_t;

    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  finished;
        logic [PROC_W-1:0] position;
        logic [PROC_W-1:0] proc_id;
        logic              last;
    } result_t;

    typedef struct packed {
        amt_t [NRES-1:0]              avail;
        amt_t [NPROC-1:0][NRES-1:0]   alloc;
        amt_t [NPROC-1:0][NRES-1:0]   need;
        logic [NPROC-1:0][PROC_W-1:0] order;
    } bank_t;

    typedef struct packed {
        op_item_t item;
        logic     drain;
    } pending_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     drv_valid = 1'b0;
    op_item_t drv_item = '0;
    logic     take_ready = 1'b0;

    pending_t backlog[$];
    result_t  expected_results[$];
    bank_t    book = '0;
    bank_t    plan = '0;

    int issued = 0;
    int seen = 0;
    int fault_count = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    int tail_mark = ITEM_TARGET;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bsa_req_if req_ch ();
    bsa_rsp_if rsp_ch ();

    assign req_ch.valid     = drv_valid;
    assign req_ch.operation = drv_item.operation;
    assign req_ch.process   = drv_item.proc_id;
    assign req_ch.resource  = drv_item.resource;
    assign req_ch.amount_a  = drv_item.amount[0];
    assign req_ch.amount_b  = drv_item.amount[1];
    assign req_ch.amount_c  = drv_item.amount[2];
    assign req_ch.extra_a   = drv_item.extra[0];
    assign req_ch.extra_b   = drv_item.extra[1];
    assign req_ch.extra_c   = drv_item.extra[2];
    assign rsp_ch.ready     = take_ready;

    banker_safety_allocator_top #(
        .PROCESSES(PROCESSES_DEFAULT)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    function automatic logic [CNT_W-1:0] scan_for_safe_order(inout bank_t b);
        int   work [NRES];
        logic done [NPROC];
        int   cnt;
        int   p;
        logic fits;
        for (int r = 0; r < NRES; r++)
            work[r] = int'(b.avail[r]);
        for (int q = 0; q < NPROC; q++)
            done[q] = 1'b0;
        cnt = 0;
        p = 0;
        while (p < NPROC)
        begin
            fits = !done[p];
            for (int r = 0; r < NRES; r++)
                if (int'(b.need[p][r]) > work[r])
                    fits = 1'b0;
            if (fits)
            begin
                for (int r = 0; r < NRES; r++)
                    work[r] = work[r] + int'(b.alloc[p][r]);
                done[p] = 1'b1;
                b.order[cnt] = p[PROC_W-1:0];
                cnt++;
                p = 0;
            end
            else
                p++;
        end
        return cnt[CNT_W-1:0];
    endfunction

    function automatic void bank_step(inout bank_t b, input op_item_t it,
                                      output result_t [NPROC-1:0] outs, output int n);
        int               ip;
        int               ir;
        int               num;
        logic [CNT_W-1:0] done_cnt;
        outs = '0;
        n = 1;
        outs[0].last = 1'b1;
        ip = int'(it.proc_id);
        ir = int'(it.resource);
        case (it.operation)
            OP_REQUEST:
            begin
                if (ip >= NPROC)
                begin
                    outs[0].status = ST_OVER_NEED;
                    return;
                end
                for (int r = 0; r < NRES; r++)
                begin
                    if (it.amount[r] > b.need[ip][r])
                    begin
                        outs[0].status = ST_OVER_NEED;
                        return;
                    end
                    if (it.amount[r] > b.avail[r] ||
                        int'(it.amount[r]) + int'(b.alloc[ip][r]) > AMT_MAX)
                    begin
                        outs[0].status = ST_OVER_AVAIL;
                        return;
                    end
                end
                for (int r = 0; r < NRES; r++)
                begin
                    b.avail[r]     = b.avail[r] - it.amount[r];
                    b.alloc[ip][r] = b.alloc[ip][r] + it.amount[r];
                    b.need[ip][r]  = b.need[ip][r] - it.amount[r];
                end
                done_cnt = scan_for_safe_order(b);
                if (int'(done_cnt) == NPROC)
                begin
                    n = NPROC;
                    for (int k = 0; k < NPROC; k++)
                    begin
                        outs[k].status   = ST_GRANTED;
                        outs[k].finished = done_cnt;
                        outs[k].position = k[PROC_W-1:0];
                        outs[k].proc_id  = b.order[k];
                        outs[k].last     = (k == NPROC - 1);
                    end
                end
                else
                begin
                    for (int r = 0; r < NRES; r++)
                    begin
                        b.avail[r]     = b.avail[r] + it.amount[r];
                        b.alloc[ip][r] = b.alloc[ip][r] - it.amount[r];
                        b.need[ip][r]  = b.need[ip][r] + it.amount[r];
                    end
                    outs[0].status   = ST_UNSAFE;
                    outs[0].finished = done_cnt;
                end
            end
            OP_RELEASE:
            begin
                num = int'(it.amount[0]);
                if (ip >= NPROC || ir >= NRES)
                    outs[0].status = ST_REFUSED;
                else if (num > int'(b.alloc[ip][ir]) ||
                         int'(b.avail[ir]) + num > AMT_MAX ||
                         int'(b.need[ip][ir]) + num > AMT_MAX)
                    outs[0].status = ST_REFUSED;
                else
                begin
                    b.avail[ir]     = b.avail[ir] + it.amount[0];
                    b.alloc[ip][ir] = b.alloc[ip][ir] - it.amount[0];
                    b.need[ip][ir]  = b.need[ip][ir] + it.amount[0];
                    outs[0].status  = ST_GRANTED;
                end
            end
            OP_LOAD_ROW:
            begin
                if (ip < NPROC)
                begin
                    b.alloc[ip] = it.amount;
                    b.need[ip]  = it.extra;
                end
                outs[0].status = ST_LOADED;
            end
            OP_LOAD_AVAIL:
            begin
                b.avail = it.amount;
                outs[0].status = ST_LOADED;
            end
        endcase
    endfunction

    function automatic op_item_t make_item(op_t op, int pid, int rid,
                                           int a0, int a1, int a2,
                                           int x0, int x1, int x2);
        op_item_t it;
        it.operation = op;
        it.proc_id   = pid[PROC_W-1:0];
        it.resource  = rid[RES_W-1:0];
        it.amount[0] = a0[AMT_W-1:0];
        it.amount[1] = a1[AMT_W-1:0];
        it.amount[2] = a2[AMT_W-1:0];
        it.extra[0]  = x0[AMT_W-1:0];
        it.extra[1]  = x1[AMT_W-1:0];
        it.extra[2]  = x2[AMT_W-1:0];
        return it;
    endfunction

    function automatic op_item_t random_item();
        return make_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 3),
                         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    task automatic stage(input op_item_t it, input logic drain);
        result_t [NPROC-1:0] scratch;
        int                  n;
        bank_step(plan, it, scratch, n);
        backlog = {backlog, pending_t'{item: it, drain: drain}};
    endtask

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fault_count++;
    endtask

    initial
    begin : stimulus
        int   scale;
        int   p;
        int   r;
        int   hi;
        int   pick;
        int   amt [NRES];
        logic drain;

        stage(make_item(OP_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_LOAD_AVAIL, 0, 0, 3, 3, 2, 0, 0, 0), 1'b0);
        stage(make_item(OP_LOAD_ROW, 0, 0, 0, 1, 0, 7, 4, 3), 1'b0);
        stage(make_item(OP_LOAD_ROW, 1, 0, 2, 0, 0, 1, 2, 2), 1'b0);
        stage(make_item(OP_LOAD_ROW, 2, 0, 3, 0, 2, 6, 0, 0), 1'b0);
        stage(make_item(OP_LOAD_ROW, 3, 0, 2, 1, 1, 0, 1, 1), 1'b0);
        stage(make_item(OP_LOAD_ROW, 4, 0, 0, 0, 2, 4, 3, 1), 1'b0);
        stage(make_item(OP_REQUEST, 1, 0, 1, 0, 2, 0, 0, 0), 1'b0);
        stage(make_item(OP_REQUEST, 4, 0, 3, 3, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_REQUEST, 0, 0, 0, 2, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_REQUEST, 0, 0, 8, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_REQUEST, 3, 0, 0, 0, 2, 0, 0, 0), 1'b0);
        stage(make_item(OP_REQUEST, 6, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_RELEASE, 1, 0, 1, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_RELEASE, 1, 0, 200, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_RELEASE, 7, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_RELEASE, 2, 3, 0, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_LOAD_ROW, 5, 3, 255, 255, 255, 255, 255, 255), 1'b0);
        stage(make_item(OP_LOAD_AVAIL, 7, 3, 255, 255, 255, 255, 255, 255), 1'b0);
        stage(make_item(OP_RELEASE, 0, 1, 1, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_LOAD_ROW, 4, 0, 255, 255, 255, 255, 255, 255), 1'b0);
        stage(make_item(OP_LOAD_AVAIL, 0, 0, 1, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_RELEASE, 4, 2, 1, 0, 0, 0, 0, 0), 1'b0);
        stage(make_item(OP_REQUEST, 4, 0, 1, 0, 0, 0, 0, 0), 1'b0);

        drain = 1'b1;
        while (backlog.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 3))
                    0: scale = 3;
                    1: scale = 15;
                    2: scale = 60;
                    default: scale = 255;
                endcase
                stage(make_item(OP_LOAD_AVAIL, $urandom_range(0, 7), $urandom_range(0, 3),
                                $urandom_range(scale / 2, scale),
                                $urandom_range(scale / 2, scale),
                                $urandom_range(scale / 2, scale),
                                $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255)), drain);
                for (p = 0; p < NPROC; p++)
                    stage(make_item(OP_LOAD_ROW, p, $urandom_range(0, 3),
                                    $urandom_range(0, scale), $urandom_range(0, scale),
                                    $urandom_range(0, scale), $urandom_range(0, scale),
                                    $urandom_range(0, scale), $urandom_range(0, scale)), 1'b0);
                repeat ($urandom_range(3, 10))
                begin
                    pick = $urandom_range(0, 19);
                    p = $urandom_range(0, NPROC - 1);
                    if (pick < 13)
                    begin
                        for (r = 0; r < NRES; r++)
                        begin
                            hi = int'(plan.need[p][r]);
                            if (int'(plan.avail[r]) < hi)
                                hi = int'(plan.avail[r]);
                            amt[r] = $urandom_range(0, hi);
                        end
                        stage(make_item(OP_REQUEST, p, $urandom_range(0, 3),
                                        amt[0], amt[1], amt[2],
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255)), 1'b0);
                    end
                    else if (pick < 17)
                    begin
                        r = $urandom_range(0, NRES - 1);
                        stage(make_item(OP_RELEASE, p, r,
                                        $urandom_range(0, int'(plan.alloc[p][r])),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255)), 1'b0);
                    end
                    else
                        stage(random_item(), 1'b0);
                end
            end
            else
            begin
                stage(random_item(), drain);
                repeat ($urandom_range(0, 5))
                    stage(random_item(), 1'b0);
            end
            drain = ($urandom_range(0, 3) == 0);
        end
        tail_mark = backlog.size() - CALM_TAIL;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (backlog.size() != 0 || drv_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("PASS banker_safety_allocator_top");
        else
            $display("FAIL banker_safety_allocator_top");
        $finish;
    end

    always @(posedge clk)
    begin : drive_items
        result_t [NPROC-1:0] outs;
        int                  n;
        logic                fire;
        if (rst_n)
        begin
            fire = drv_valid && req_ch.ready;
            if (fire)
            begin
                bank_step(book, drv_item, outs, n);
                for (int k = 0; k < n; k++)
                    expected_results = {expected_results, outs[k]};
                issued++;
                if (issued < tail_mark && (issued / 30) % 3 != 1 && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 13);
            end
            if (!drv_valid || fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end
                else if (backlog.size() == 0 ||
                         (backlog[0].drain && expected_results.size() != 0))
                    drv_valid <= 1'b0;
                else
                begin
                    drv_item  <= backlog[0].item;
                    drv_valid <= 1'b1;
                    backlog.pop_front();
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && take_ready)
            begin
                seen++;
                if (expected_results.size() == 0)
                    flag_mismatch($sformatf("result %0d arrived with nothing outstanding", seen));
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                seen, rsp_ch.status, want.status));
                    if (rsp_ch.finished_count !== want.finished)
                        flag_mismatch($sformatf("result %0d finished_count %0d, want %0d",
                                                seen, rsp_ch.finished_count, want.finished));
                    if (rsp_ch.seq_position !== want.position)
                        flag_mismatch($sformatf("result %0d seq_position %0d, want %0d",
                                                seen, rsp_ch.seq_position, want.position));
                    if (rsp_ch.seq_process !== want.proc_id)
                        flag_mismatch($sformatf("result %0d seq_process %0d, want %0d",
                                                seen, rsp_ch.seq_process, want.proc_id));
                    if (rsp_ch.last !== want.last)
                        flag_mismatch($sformatf("result %0d last %0d, want %0d",
                                                seen, rsp_ch.last, want.last));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                take_ready <= 1'b0;
            end
            else
            begin
                take_ready <= 1'b1;
                if (issued < tail_mark && (seen / 40) % 3 != 2 && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((drv_valid && req_ch.ready) || (rsp_ch.valid && take_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL banker_safety_allocator_top");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
